// ===== rtl/gtg_pkg.sv =====
// package: widths, register indexes and cordic angle table for the go-to-goal controller
`timescale 1ns / 1ps
package gtg_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AtanEntries    = 24;
  localparam int ZW             = 28;   // q24 angle accumulator
  localparam int VW             = 48;   // prescaled cordic vector
  localparam int NW             = 50;   // squared distance sum
  localparam int DistW          = 25;

  localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
  localparam logic signed [15:0]   PiQ12     = 16'sd12868;
  localparam logic signed [15:0]   TwoPiQ12  = 16'sd25736;

  typedef enum logic [2:0] {
    REG_HEADING_GAIN  = 3'd0,
    REG_ANGULAR_LIMIT = 3'd1,
    REG_HEADING_GATE  = 3'd2,
    REG_LINEAR_MAX    = 3'd3,
    REG_DISTANCE_GAIN = 3'd4,
    REG_STOP_RADIUS   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] heading_gain;
    logic [14:0] angular_limit;
    logic [13:0] heading_gate;
    logic [14:0] linear_max;
    logic [15:0] distance_gain;
    logic [23:0] stop_radius;
  } cfg_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 28'sd13176795;
        1: r = 28'sd7778716;
        2: r = 28'sd4110060;
        3: r = 28'sd2086331;
        4: r = 28'sd1047214;
        5: r = 28'sd524117;
        6: r = 28'sd262123;
        7: r = 28'sd131069;
        default: r = (i < AtanEntries) ? ZW'(28'sd65536 >>> (i - 8)) : '0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/gtg_cordic.sv =====
// pipelined vectoring cordic: one rotation per stage, angle out in q24
`timescale 1ns / 1ps
module gtg_cordic #(
  parameter int STEPS = gtg_pkg::CordicStepsDef
) (
  input  logic                          clk,
  input  logic signed [24:0]            dx,
  input  logic signed [24:0]            dy,
  output logic signed [gtg_pkg::ZW-1:0] z_out
);
  import gtg_pkg::*;

  localparam int N = (STEPS > AtanEntries) ? AtanEntries : STEPS;

  logic signed [VW-1:0] x_r [N+1];
  logic signed [VW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic                 zero_r [N+1];

  logic signed [VW-1:0] px, py;
  logic                 pzero;

  always_comb begin
    px = VW'(dx) <<< 20;
    py = VW'(dy) <<< 20;
    pzero = (dx == '0) && (dy == '0);
  end

  // quadrant fold into the right half plane
  always_ff @(posedge clk) begin
    zero_r[0] <= pzero;
    if (px < 0) begin
      if (py >= 0) begin
        x_r[0] <= py;  y_r[0] <= -px; z_r[0] <= HalfPiQ24;
      end else begin
        x_r[0] <= -py; y_r[0] <= px;  z_r[0] <= -HalfPiQ24;
      end
    end else begin
      x_r[0] <= px; y_r[0] <= py; z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_q24(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_q24(i);
      end
    end
  end

  assign z_out = zero_r[N] ? '0 : z_r[N];

endmodule

// ===== rtl/gtg_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module gtg_isqrt (
  input  logic                            clk,
  input  logic [gtg_pkg::NW-1:0]          n_in,
  output logic [gtg_pkg::DistW-1:0]       root
);
  import gtg_pkg::*;

  localparam int S = DistW;

  logic [NW-1:0]    rem_r  [S+1];
  logic [DistW-1:0] res_r  [S+1];

  always_comb begin
    rem_r[0] = n_in;
    res_r[0] = '0;
  end

  for (genvar k = 0; k < S; k++) begin : g_bit
    localparam int B = S - 1 - k;
    logic [NW+1:0] trial;
    assign trial = ({2'b0, NW'(res_r[k])} << (B + 1)) + ((NW + 2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if ({2'b0, rem_r[k]} >= trial) begin
        rem_r[k+1] <= rem_r[k] - NW'(trial);
        res_r[k+1] <= res_r[k] | (DistW'(1) << B);
      end else begin
        rem_r[k+1] <= rem_r[k];
        res_r[k+1] <= res_r[k];
      end
    end
  end

  assign root = res_r[S];

endmodule

// ===== rtl/gtg_control.sv =====
// control law stages: wrap, gains, clamps and arrival test
`timescale 1ns / 1ps
module gtg_control (
  input  logic                        clk,
  input  gtg_pkg::cfg_t               cfg,
  input  logic signed [gtg_pkg::ZW-1:0] z_q24,
  input  logic signed [14:0]          yaw,
  input  logic [gtg_pkg::DistW-1:0]   dist_in,
  output logic [14:0]                 lin,
  output logic signed [15:0]          ang,
  output logic signed [14:0]          err,
  output logic [gtg_pkg::DistW-1:0]   dist_out,
  output logic                        arrived
);
  import gtg_pkg::*;

  // stage a: round bearing, subtract yaw, wrap once
  logic signed [17:0] bear, e0;
  logic signed [15:0] err_a_r;
  logic [DistW-1:0]   dist_a_r;
  always_comb begin
    bear = 18'((z_q24 + ZW'(2048)) >>> 12);
    e0 = bear - 18'(yaw);
    if (e0 > 18'(PiQ12)) e0 = e0 - 18'(TwoPiQ12);
    else if (e0 < -18'(PiQ12)) e0 = e0 + 18'(TwoPiQ12);
  end
  always_ff @(posedge clk) begin
    err_a_r  <= 16'(e0);
    dist_a_r <= dist_in;
  end

  // stage b: products and arrival compare
  logic signed [33:0] pa_r;
  logic [40:0]        pl_r;
  logic signed [15:0] err_b_r;
  logic [DistW-1:0]   dist_b_r;
  logic               arr_b_r;
  always_ff @(posedge clk) begin
    pa_r     <= 34'(err_a_r) * $signed({18'b0, cfg.heading_gain});
    pl_r     <= 41'(cfg.distance_gain) * 41'(dist_a_r);
    err_b_r  <= err_a_r;
    dist_b_r <= dist_a_r;
    arr_b_r  <= {1'b0, dist_a_r} <= {2'b0, cfg.stop_radius};
  end

  // stage c: round, clamp, gate, zero outputs on arrival
  logic signed [22:0] ar;
  logic [28:0]        lr;
  logic signed [22:0] lim;
  logic [15:0]        mag;
  logic signed [15:0] ang_n;
  logic [14:0]        lin_n;
  always_comb begin
    ar  = 23'((pa_r + 34'sd2048) >>> 12);
    lr  = 29'((pl_r + 41'd2048) >> 12);
    lim = 23'(cfg.angular_limit);
    if (ar > lim) ang_n = 16'(lim);
    else if (ar < -lim) ang_n = 16'(-lim);
    else ang_n = 16'(ar);
    mag = err_b_r < 0 ? 16'(-err_b_r) : 16'(err_b_r);
    if (mag > 16'(cfg.heading_gate)) lin_n = '0;
    else if (lr > 29'(cfg.linear_max)) lin_n = cfg.linear_max;
    else lin_n = 15'(lr);
    if (arr_b_r) begin
      lin_n = '0;
      ang_n = '0;
    end
  end
  always_ff @(posedge clk) begin
    lin      <= lin_n;
    ang      <= ang_n;
    err      <= 15'(err_b_r);
    dist_out <= dist_b_r;
    arrived  <= arr_b_r;
  end

endmodule

// ===== rtl/go_to_goal_controller_unit.sv =====
// top level: config registers, front-end deltas, cordic and sqrt, control law
`timescale 1ns / 1ps
// Go-to-goal controller. Takes one item per clock (start while busy is low;
// busy is always low) and returns each result on out_valid for one cycle.
// For any CORDIC_STEPS up to 24 the depth is set by the delta stage, the
// square stage and the 25-stage square root (the cordic, fold plus one
// stage per rotation, runs alongside and is padded to match), then three
// control stages. The receiver cannot stall, so nothing backs up.
// Configuration writes take effect at once and should be made only while no
// item is in flight.
module go_to_goal_controller_unit #(
  parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_robot_x,
  input  logic signed [23:0] in_robot_y,
  input  logic signed [14:0] in_robot_yaw,
  input  logic signed [23:0] in_goal_x,
  input  logic signed [23:0] in_goal_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  output logic [14:0]        out_fwd_speed,
  output logic signed [15:0] out_turn_rate,
  output logic signed [14:0] out_heading_error,
  output logic [24:0]        out_goal_distance,
  output logic               out_arrived
);
  import gtg_pkg::*;

  localparam int N   = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam int CL  = N + 1;       // cordic latency after delta stage
  localparam int SL  = DistW;       // sqrt latency after square stage
  localparam int AL  = (CL > SL + 1) ? CL : SL + 1;
  localparam int LAT = AL + 4;

  cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{16'd8192, 15'd2048, 14'd3217, 15'd410, 16'd819, 24'd1229};
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_HEADING_GAIN:  cfg_r.heading_gain  <= cfg_data[15:0];
        REG_ANGULAR_LIMIT: cfg_r.angular_limit <= cfg_data[14:0];
        REG_HEADING_GATE:  cfg_r.heading_gate  <= cfg_data[13:0];
        REG_LINEAR_MAX:    cfg_r.linear_max    <= cfg_data[14:0];
        REG_DISTANCE_GAIN: cfg_r.distance_gain <= cfg_data[15:0];
        REG_STOP_RADIUS:   cfg_r.stop_radius   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic               acc;
  assign acc = start && !busy;

  // delta stage
  logic signed [24:0] dx_r, dy_r;
  logic signed [14:0] yaw_r;
  always_ff @(posedge clk) begin
    dx_r  <= 25'(in_goal_x) - 25'(in_robot_x);
    dy_r  <= 25'(in_goal_y) - 25'(in_robot_y);
    yaw_r <= in_robot_yaw;
  end

  // square stage
  logic [NW-1:0] sq_r;
  always_ff @(posedge clk) begin
    sq_r <= $unsigned(NW'(dx_r) * NW'(dx_r)) + $unsigned(NW'(dy_r) * NW'(dy_r));
  end

  logic signed [ZW-1:0] z;
  logic [DistW-1:0]     root;
  gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .dx(dx_r), .dy(dy_r), .z_out(z)
  );
  gtg_isqrt u_isqrt (.clk(clk), .n_in(sq_r), .root(root));

  // align both branches to AL stages past the delta stage
  logic signed [ZW-1:0] zd_r [AL-CL+1];
  logic [DistW-1:0]     rd_r [AL-SL];
  logic signed [14:0]   yd_r [AL+1];
  assign zd_r[0] = z;
  assign rd_r[0] = root;
  assign yd_r[0] = yaw_r;
  for (genvar k = 0; k < AL - CL; k++) begin : g_zd
    always_ff @(posedge clk) zd_r[k+1] <= zd_r[k];
  end
  for (genvar k = 0; k < AL - SL - 1; k++) begin : g_rd
    always_ff @(posedge clk) rd_r[k+1] <= rd_r[k];
  end
  for (genvar k = 0; k < AL; k++) begin : g_yd
    always_ff @(posedge clk) yd_r[k+1] <= yd_r[k];
  end

  gtg_control u_ctl (
    .clk(clk), .cfg(cfg_r), .z_q24(zd_r[AL-CL]), .yaw(yd_r[AL]),
    .dist_in(rd_r[AL-SL-1]), .lin(out_fwd_speed), .ang(out_turn_rate),
    .err(out_heading_error), .dist_out(out_goal_distance), .arrived(out_arrived)
  );

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], acc};
  end
  assign out_valid = vld_r[LAT-1];

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_vld_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[LAT-2])) else $error("valid skipped a stage");
  a_arr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_fwd_speed == '0 && out_turn_rate == '0)
    else $error("speed while arrived");
  a_err_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_heading_error <= 15'sd12868 && out_heading_error >= -15'sd12868))
    else $error("heading error not wrapped");
`endif

endmodule
